/* src/otb_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the on/off delay timer bank: field widths, command
// and register codes, reset values and the controller/datapath signal groups.
// No dependencies.
package otb_pkg;

  localparam int unsigned TIMERS_DEFAULT = 8;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned SCAN_W    = 10;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WR_EN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WR_TYPE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WR_DELAY = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 2'd2;

  localparam logic [SCAN_W-1:0] SCAN_RESET = 10'd10;
  localparam logic [SCAN_W-1:0] SCAN_LO    = 10'd1;
  localparam logic [SCAN_W-1:0] SCAN_HI    = 10'd1000;
  localparam logic [VAL_W-1:0]  MIN_DELAY_RESET = 16'd0;
  localparam logic [VAL_W-1:0]  MAX_DELAY_RESET = 16'hFFFF;

  typedef struct packed {
    logic load_cmd;
    logic exec;
    logic tick_step;
    logic load_out;
  } otb_ctrl_t;

  typedef struct packed {
    logic cmd_tick;
    logic walk_last;
  } otb_stat_t;

endpackage

/* src/otb_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the timer bank: command input, result output and
// register write. Depends on otb_pkg.
interface otb_in_if import otb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] timer_index;
  logic [VAL_W-1:0] write_value;

  modport source (output valid, output cmd, output timer_index, output write_value,
                  input ready);
  modport sink (input valid, input cmd, input timer_index, input write_value,
                output ready);
endinterface

interface otb_out_if import otb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              timer_output;
  logic              timer_done;
  logic [MASK_W-1:0] output_mask;
  logic [MASK_W-1:0] done_mask;

  modport source (output valid, output timer_output, output timer_done,
                  output output_mask, output done_mask, input ready);
  modport sink (input valid, input timer_output, input timer_done,
                input output_mask, input done_mask, output ready);
endinterface

interface otb_cfg_if import otb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/otb_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the timer bank: sequences accept, execute, tick walk and
// result load, and owns the result valid flag. Depends on otb_pkg.
module otb_ctrl import otb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  otb_stat_t stat_i,
  output otb_ctrl_t ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_cmd = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.cmd_tick) begin
          state_d = S_TICK;
        end else begin
          ctrl_o.exec = 1'b1;
          state_d     = S_RESP;
        end
      end
      S_TICK: begin
        ctrl_o.tick_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ctrl_o.load_out = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/otb_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the timer bank: timer state, configuration registers, the
// shared tick update unit and the result register. Depends on otb_pkg.
module otb_datapath import otb_pkg::*; #(
  parameter int unsigned TIMERS = TIMERS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  otb_ctrl_t            ctrl_i,
  output otb_stat_t            stat_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [IDX_W-1:0]     timer_index_i,
  input  logic [VAL_W-1:0]     write_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  output logic                 timer_output_o,
  output logic                 timer_done_o,
  output logic [MASK_W-1:0]    output_mask_o,
  output logic [MASK_W-1:0]    done_mask_o
);

  localparam int unsigned IdxW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned PadW = (TIMERS > MASK_W) ? TIMERS : MASK_W;
  localparam logic [IDX_W:0]  TimersCount = (IDX_W + 1)'(TIMERS);
  localparam logic [IdxW-1:0] LastTimer   = IdxW'(TIMERS - 1);

  logic [CMD_W-1:0]  cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VAL_W-1:0]  wv_q;
  logic [IdxW-1:0]   walk_q;

  logic [SCAN_W-1:0] scan_q;
  logic [VAL_W-1:0]  min_delay_q;
  logic [VAL_W-1:0]  max_delay_q;

  logic [TIMERS-1:0] en_q;
  logic [TIMERS-1:0] type_q;
  logic [TIMERS-1:0] run_q;
  logic [TIMERS-1:0] out_q;
  logic [TIMERS-1:0] done_q;
  logic [VAL_W-1:0]  delay_q   [TIMERS];
  logic [VAL_W-1:0]  elapsed_q [TIMERS];

  logic              res_out_q, res_done_q;
  logic [MASK_W-1:0] omask_q, dmask_q;

  logic              idx_ok;
  logic [IdxW-1:0]   addr;
  logic [SCAN_W-1:0] scan_eff;
  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  sum_sat;
  logic              tick_live;
  logic              tick_hit;
  logic [VAL_W-1:0]  delay_hi;
  logic [VAL_W-1:0]  delay_clamped;
  logic [PadW-1:0]   out_pad, done_pad;

  assign idx_ok = ({1'b0, idx_q} < TimersCount);
  assign addr   = idx_q[IdxW-1:0];

  assign stat_o.cmd_tick  = (cmd_q == CMD_TICK);
  assign stat_o.walk_last = (walk_q == LastTimer);

  always_comb begin
    if (scan_q < SCAN_LO) begin
      scan_eff = SCAN_LO;
    end else if (scan_q > SCAN_HI) begin
      scan_eff = SCAN_HI;
    end else begin
      scan_eff = scan_q;
    end
  end

  assign sum       = {1'b0, elapsed_q[walk_q]} + (VAL_W + 1)'(scan_eff);
  assign sum_sat   = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
  assign tick_live = en_q[walk_q] && run_q[walk_q] && !done_q[walk_q];
  assign tick_hit  = (sum_sat >= delay_q[walk_q]);

  assign delay_hi      = (wv_q > max_delay_q) ? max_delay_q : wv_q;
  assign delay_clamped = (delay_hi < min_delay_q) ? min_delay_q : delay_hi;

  assign out_pad  = PadW'(out_q);
  assign done_pad = PadW'(done_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_cmd) begin
      cmd_q <= cmd_i;
      idx_q <= timer_index_i;
      wv_q  <= write_value_i;
    end
    if (ctrl_i.load_out) begin
      res_out_q  <= idx_ok ? out_q[addr] : 1'b0;
      res_done_q <= idx_ok ? done_q[addr] : 1'b0;
      omask_q    <= out_pad[MASK_W-1:0];
      dmask_q    <= done_pad[MASK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (ctrl_i.load_cmd) begin
      walk_q <= '0;
    end else if (ctrl_i.tick_step) begin
      walk_q <= walk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= SCAN_RESET;
      min_delay_q <= MIN_DELAY_RESET;
      max_delay_q <= MAX_DELAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCAN_TIME: scan_q      <= cfg_data_i[SCAN_W-1:0];
        CFG_MIN_DELAY: min_delay_q <= cfg_data_i;
        CFG_MAX_DELAY: max_delay_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      type_q <= '0;
      run_q  <= '0;
      out_q  <= '0;
      done_q <= '0;
      for (int i = 0; i < TIMERS; i++) begin
        delay_q[i]   <= '0;
        elapsed_q[i] <= '0;
      end
    end else if (ctrl_i.exec && idx_ok) begin
      case (cmd_q)
        CMD_START, CMD_STOP: begin
          if (en_q[addr]) begin
            run_q[addr]     <= (cmd_q == CMD_START);
            elapsed_q[addr] <= '0;
            out_q[addr]     <= type_q[addr];
            done_q[addr]    <= 1'b0;
          end
        end
        CMD_WR_EN: begin
          en_q[addr] <= wv_q[0];
          if (wv_q[0]) begin
            run_q[addr]     <= 1'b0;
            elapsed_q[addr] <= '0;
            out_q[addr]     <= type_q[addr];
            done_q[addr]    <= 1'b0;
          end
        end
        CMD_WR_TYPE: begin
          type_q[addr] <= wv_q[0];
          if (en_q[addr]) begin
            run_q[addr]     <= 1'b0;
            elapsed_q[addr] <= '0;
            out_q[addr]     <= wv_q[0];
            done_q[addr]    <= 1'b0;
          end
        end
        CMD_WR_DELAY: begin
          delay_q[addr] <= delay_clamped;
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.tick_step && tick_live) begin
      if (tick_hit) begin
        elapsed_q[walk_q] <= '0;
        out_q[walk_q]     <= !type_q[walk_q];
        done_q[walk_q]    <= 1'b1;
      end else begin
        elapsed_q[walk_q] <= sum_sat;
      end
    end
  end

  assign timer_output_o = res_out_q;
  assign timer_done_o   = res_done_q;
  assign output_mask_o  = omask_q;
  assign done_mask_o    = dmask_q;

endmodule

/* src/on_off_delay_timer_bank.sv */
`timescale 1ns / 1ps
// Bank of TIMERS on-delay/off-delay timers. A command other than tick is executed, then its
// result is loaded to the output; a tick first walks every timer, as one update unit walks one
// timer per cycle. The next transfer is taken in the cycle after the result is loaded, so
// a new command is not taken while another is in work. A result waiting at the output
// holds the next finished command until it is taken. Reset clears all timers at once and
// loads scan time 10, minimum delay 0 and maximum delay 65535.
module on_off_delay_timer_bank import otb_pkg::*; #(
  parameter int unsigned TIMERS = TIMERS_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  otb_in_if.sink   in_i,
  otb_out_if.source out_o,
  otb_cfg_if.sink  cfg_i
);

  otb_ctrl_t ctrl;
  otb_stat_t stat;

  assign cfg_i.ready = 1'b1;

  otb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  otb_datapath #(
    .TIMERS (TIMERS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (in_i.cmd),
    .timer_index_i  (in_i.timer_index),
    .write_value_i  (in_i.write_value),
    .cfg_we_i       (cfg_i.valid && cfg_i.ready),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .timer_output_o (out_o.timer_output),
    .timer_done_o   (out_o.timer_done),
    .output_mask_o  (out_o.output_mask),
    .done_mask_o    (out_o.done_mask)
  );

  // Only one command is in work until its result has been loaded.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("command transfer taken while another is in work");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |=> out_o.valid)
    else $error("loaded result not presented");

  // The controller issues at most one datapath command per cycle.
  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.load_cmd, ctrl.exec, ctrl.tick_step, ctrl.load_out}))
    else $error("conflicting datapath commands");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> !out_o.valid || out_o.ready)
    else $error("pending result overwritten");

endmodule
